>>> hw/rtl/rgb_fader_button_controller_assert.svh
// Assertion macros for the RGB fader button controller.
// Used by the top level only; expects clk and rst in scope.
`ifndef RGB_FADER_BUTTON_CONTROLLER_ASSERT_SVH
`define RGB_FADER_BUTTON_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// Check on every edge outside reset
`define RFBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rfbc: assertion failed");
// Check on every edge, reset included
`define RFBC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rfbc: reset assertion failed");
`else
`define RFBC_ASSERT(label, prop)
`define RFBC_ASSERT_RST(label, prop)
`endif
`endif

>>> hw/rtl/rfbc_pkg.sv
// Package for the RGB fader button controller: payload structs, mode codes,
// level and counter limits, and the constant-divider factors. No dependencies.
package rfbc_pkg;

  localparam int unsigned PULSE_W = 15;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PROD_W = LEVEL_W + PERIOD_W;

  // Colour level limits
  localparam logic [7:0] LEVEL_MAX = 8'd254;
  localparam logic [7:0] LEVEL_MIN = 8'd10;

  // Fade speed limits
  localparam logic [6:0] SPEED_MAX = 7'd100;
  localparam logic [6:0] SPEED_MIN = 7'd1;

  // Button counters
  localparam logic [4:0] HOLD_SHORT   = 5'd20;
  localparam logic [4:0] REPEAT_AFTER = 5'd30;
  localparam logic [4:0] HOLD_SAT     = 5'd31;
  localparam logic [1:0] PRESS_SAT    = 2'd3;
  localparam logic [1:0] PRESS_ONE    = 2'd1;
  localparam logic [1:0] PRESS_TWO    = 2'd2;

  // Fade phase flags
  localparam logic [2:0] PHASE_RG = 3'b001;
  localparam logic [2:0] PHASE_GB = 3'b010;
  localparam logic [2:0] PHASE_BR = 3'b100;

  // Reset values
  localparam logic [7:0]  RED_RESET    = 8'd254;
  localparam logic [7:0]  GREEN_RESET  = 8'd10;
  localparam logic [7:0]  BLUE_RESET   = 8'd10;
  localparam logic [15:0] PERIOD_RESET = 16'd11362;

  // speed / 10 as (speed * 205) >> 11, exact for speed below 128
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  // x / 1000 as (x * ceil(2^34 / 1000)) >> 34, exact for x below 2^24
  localparam int unsigned RECIP_SHIFT = 34;
  localparam int unsigned RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 25'd17179870;
  localparam int unsigned QUOT_W      = PROD_W + RECIP_W;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_GREEN = 2'd2,
    MODE_BLUE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic inc_button;
    logic dec_button;
  } tick_t;

  typedef struct packed {
    logic [PULSE_W-1:0] red_pulse;
    logic [PULSE_W-1:0] green_pulse;
    logic [PULSE_W-1:0] blue_pulse;
    logic [1:0]         mode_now;
  } pulse_t;

  // Levels and mode after one tick's update
  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    mode_t              op_mode;
  } lvl_t;

endpackage

>>> hw/rtl/rfbc_scale.sv
// One colour lane of the pulse scaler: level * period, then / 1000 by
// reciprocal multiply, each product registered. Depends on rfbc_pkg.
module rfbc_scale (
  input  logic                              clk,
  input  logic [rfbc_pkg::LEVEL_W-1:0]      level,
  input  logic [rfbc_pkg::PERIOD_W-1:0]     period,
  input  logic                              prod_load,
  input  logic                              pulse_load,
  output logic [rfbc_pkg::PULSE_W-1:0]      pulse
);

  logic [rfbc_pkg::PROD_W-1:0] prod;
  logic [rfbc_pkg::QUOT_W-1:0] quot_full;

  // Stage one: scale level by period
  always_ff @(posedge clk) begin
    if (prod_load) begin
      prod <= rfbc_pkg::PROD_W'(level) * rfbc_pkg::PROD_W'(period);
    end
  end

  // Stage two: divide by 1000 through the reciprocal
  assign quot_full = rfbc_pkg::QUOT_W'(prod) * rfbc_pkg::QUOT_W'(rfbc_pkg::RECIP_MUL);

  always_ff @(posedge clk) begin
    if (pulse_load) begin
      pulse <= quot_full[rfbc_pkg::RECIP_SHIFT +: rfbc_pkg::PULSE_W];
    end
  end

endmodule

>>> hw/rtl/rfbc_tick.sv
// Tick state of the RGB fader: auto fade, speed, button counters and mode.
// Updates once per transfer in and shows the updated levels. Depends on rfbc_pkg.
module rfbc_tick (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rfbc_pkg::tick_t buttons,
  output rfbc_pkg::lvl_t  lvl_next
);

  logic [7:0]      red_level, green_level, blue_level;
  logic [2:0]      fade_phase;
  logic [6:0]      fade_speed;
  rfbc_pkg::mode_t op_mode;
  logic [4:0]      inc_hold_ticks, dec_hold_ticks;
  logic [1:0]      short_press_count;

  logic [7:0]      red_level_next, green_level_next, blue_level_next;
  logic [2:0]      fade_phase_next;
  logic [6:0]      fade_speed_next;
  rfbc_pkg::mode_t op_mode_next;
  logic [4:0]      inc_hold_ticks_next, dec_hold_ticks_next;
  logic [1:0]      short_press_count_next;

  logic [14:0]     speed_mul;
  logic [3:0]      step;
  logic [8:0]      r9, g9, b9;

  function automatic logic [7:0] level_up(input logic [7:0] lv);
    level_up = (lv < rfbc_pkg::LEVEL_MAX) ? lv + 8'd1 : rfbc_pkg::LEVEL_MAX;
  endfunction

  function automatic logic [7:0] level_down(input logic [7:0] lv);
    level_down = (lv > rfbc_pkg::LEVEL_MIN) ? lv - 8'd1 : rfbc_pkg::LEVEL_MIN;
  endfunction

  // Fade step: speed / 10
  assign speed_mul = 15'(fade_speed) * 15'(rfbc_pkg::DIV10_MUL);
  assign step      = speed_mul[rfbc_pkg::DIV10_SHIFT +: 4];

  // Next state for one tick
  always_comb begin
    r9 = {1'b0, red_level};
    g9 = {1'b0, green_level};
    b9 = {1'b0, blue_level};
    fade_phase_next        = fade_phase;
    fade_speed_next        = fade_speed;
    op_mode_next           = op_mode;
    inc_hold_ticks_next    = inc_hold_ticks;
    dec_hold_ticks_next    = dec_hold_ticks;
    short_press_count_next = short_press_count;

    // Auto fade: move the step from the falling colour to the rising one
    if (op_mode == rfbc_pkg::MODE_AUTO) begin
      if (fade_phase[0]) begin
        r9 = r9 - 9'(step);
        g9 = g9 + 9'(step);
      end else if (fade_phase[1]) begin
        g9 = g9 - 9'(step);
        b9 = b9 + 9'(step);
      end else if (fade_phase[2]) begin
        b9 = b9 - 9'(step);
        r9 = r9 + 9'(step);
      end
      if (r9 < {1'b0, rfbc_pkg::LEVEL_MIN}) r9 = {1'b0, rfbc_pkg::LEVEL_MIN};
      if (g9 < {1'b0, rfbc_pkg::LEVEL_MIN}) g9 = {1'b0, rfbc_pkg::LEVEL_MIN};
      if (b9 < {1'b0, rfbc_pkg::LEVEL_MIN}) b9 = {1'b0, rfbc_pkg::LEVEL_MIN};
      // Clamp at the top and hand the fall to that colour
      if (r9 > {1'b0, rfbc_pkg::LEVEL_MAX}) begin
        r9 = {1'b0, rfbc_pkg::LEVEL_MAX};
        fade_phase_next = (fade_phase_next & ~rfbc_pkg::PHASE_BR) | rfbc_pkg::PHASE_RG;
      end
      if (g9 > {1'b0, rfbc_pkg::LEVEL_MAX}) begin
        g9 = {1'b0, rfbc_pkg::LEVEL_MAX};
        fade_phase_next = (fade_phase_next & ~rfbc_pkg::PHASE_RG) | rfbc_pkg::PHASE_GB;
      end
      if (b9 > {1'b0, rfbc_pkg::LEVEL_MAX}) begin
        b9 = {1'b0, rfbc_pkg::LEVEL_MAX};
        fade_phase_next = (fade_phase_next & ~rfbc_pkg::PHASE_GB) | rfbc_pkg::PHASE_BR;
      end
    end
    red_level_next   = r9[7:0];
    green_level_next = g9[7:0];
    blue_level_next  = b9[7:0];

    // Increment button: speed up, count the hold, step with auto-repeat
    if (buttons.inc_button) begin
      if (op_mode == rfbc_pkg::MODE_AUTO && fade_speed < rfbc_pkg::SPEED_MAX) begin
        fade_speed_next = fade_speed + 7'd1;
      end
      if (inc_hold_ticks < rfbc_pkg::HOLD_SAT) begin
        inc_hold_ticks_next = inc_hold_ticks + 5'd1;
      end
      if (inc_hold_ticks_next <= 5'd2 || inc_hold_ticks_next > rfbc_pkg::REPEAT_AFTER) begin
        unique case (op_mode_next)
          rfbc_pkg::MODE_RED:   red_level_next   = level_up(red_level_next);
          rfbc_pkg::MODE_GREEN: green_level_next = level_up(green_level_next);
          rfbc_pkg::MODE_BLUE:  blue_level_next  = level_up(blue_level_next);
          rfbc_pkg::MODE_AUTO:  ;
        endcase
      end
    end else begin
      // Release after one short press and a long hold picks red manual
      if (short_press_count == rfbc_pkg::PRESS_ONE &&
          inc_hold_ticks > rfbc_pkg::HOLD_SHORT) begin
        op_mode_next = rfbc_pkg::MODE_RED;
      end
      short_press_count_next = 2'd0;
      inc_hold_ticks_next    = 5'd0;
      dec_hold_ticks_next    = 5'd0;
    end

    // Decrement button: slow down, long hold picks blue manual, step down
    if (buttons.dec_button) begin
      if (op_mode_next == rfbc_pkg::MODE_AUTO && fade_speed_next > rfbc_pkg::SPEED_MIN) begin
        fade_speed_next = fade_speed_next - 7'd1;
      end
      if (dec_hold_ticks_next < rfbc_pkg::HOLD_SAT) begin
        dec_hold_ticks_next = dec_hold_ticks_next + 5'd1;
      end
      if (dec_hold_ticks_next > rfbc_pkg::HOLD_SHORT) begin
        op_mode_next = rfbc_pkg::MODE_BLUE;
      end
      unique case (op_mode_next)
        rfbc_pkg::MODE_RED:   red_level_next   = level_down(red_level_next);
        rfbc_pkg::MODE_GREEN: green_level_next = level_down(green_level_next);
        rfbc_pkg::MODE_BLUE:  blue_level_next  = level_down(blue_level_next);
        rfbc_pkg::MODE_AUTO:  ;
      endcase
    end else begin
      // Count a short press on release; two of them pick green manual
      if (dec_hold_ticks_next != 5'd0 && dec_hold_ticks_next <= rfbc_pkg::HOLD_SHORT &&
          short_press_count_next < rfbc_pkg::PRESS_SAT) begin
        short_press_count_next = short_press_count_next + 2'd1;
      end
      dec_hold_ticks_next = 5'd0;
      if (short_press_count_next == rfbc_pkg::PRESS_TWO) begin
        op_mode_next = rfbc_pkg::MODE_GREEN;
      end
    end
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      red_level         <= rfbc_pkg::RED_RESET;
      green_level       <= rfbc_pkg::GREEN_RESET;
      blue_level        <= rfbc_pkg::BLUE_RESET;
      fade_phase        <= rfbc_pkg::PHASE_RG;
      fade_speed        <= rfbc_pkg::SPEED_MIN;
      op_mode           <= rfbc_pkg::MODE_AUTO;
      inc_hold_ticks    <= 5'd0;
      dec_hold_ticks    <= 5'd0;
      short_press_count <= 2'd0;
    end else if (advance) begin
      red_level         <= red_level_next;
      green_level       <= green_level_next;
      blue_level        <= blue_level_next;
      fade_phase        <= fade_phase_next;
      fade_speed        <= fade_speed_next;
      op_mode           <= op_mode_next;
      inc_hold_ticks    <= inc_hold_ticks_next;
      dec_hold_ticks    <= dec_hold_ticks_next;
      short_press_count <= short_press_count_next;
    end
  end

  assign lvl_next.red_level   = red_level_next;
  assign lvl_next.green_level = green_level_next;
  assign lvl_next.blue_level  = blue_level_next;
  assign lvl_next.op_mode     = op_mode_next;

endmodule

>>> hw/rtl/rgb_fader_button_controller.sv
// RGB fader with two-button control, top level.
// Tick channel (tick_valid, tick_stall, tick_data): one transfer per update
// tick carrying the two button levels. Each tick updates the fade state,
// speed, button counters and mode at once.
// Pulse channel (pulse_valid, pulse_stall, pulse_data): one transfer per tick
// with the red, green and blue compare values (level * period / 1000) and
// the mode after that tick.
// Config channel (cfg_valid, cfg_ready, cfg_data): writes the PWM period;
// cfg_ready is always high. Write it only while no tick is in flight.
// Path: a transferred tick is registered in the product register, then moves on
// to the result register unless a stalled result holds it in the product stage.
// Throughput: one tick per cycle unless the result is stalled; the tick state
// updates on every transfer and each colour lane has one multiplier per stage.
// Reset: levels red 254, green 10, blue 10, auto mode, speed 1, period 11362,
// both pipeline stages empty.
// Stall: a stalled result holds; one more tick is taken into the product
// stage, after which tick_stall rises until the result is taken.
// Depends on rfbc_pkg, rfbc_tick, rfbc_scale and the assertion header.
`include "rgb_fader_button_controller_assert.svh"

module rgb_fader_button_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  rfbc_pkg::tick_t    tick_data,
  output logic               pulse_valid,
  input  logic               pulse_stall,
  output rfbc_pkg::pulse_t   pulse_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic [rfbc_pkg::PERIOD_W-1:0] period_load;
  rfbc_pkg::lvl_t                lvl_next;
  logic                          tick_accept;
  logic                          s1_valid;
  rfbc_pkg::mode_t               s1_mode;
  logic                          out_load;
  logic                          pulse_load;
  rfbc_pkg::mode_t               pulse_mode;
  logic [rfbc_pkg::PULSE_W-1:0]  red_pulse, green_pulse, blue_pulse;
  logic                          mode_manual;

  // Period register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_load <= rfbc_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period_load <= cfg_data;
    end
  end

  // Pipeline flow control
  assign out_load    = !pulse_valid || !pulse_stall;
  assign tick_stall  = s1_valid && !out_load;
  assign tick_accept = tick_valid && !tick_stall;
  assign pulse_load  = out_load && s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pulse_valid <= 1'b0;
    end else begin
      if (tick_accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        pulse_valid <= s1_valid;
      end
    end
  end

  // Carry the mode alongside the products
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_mode <= lvl_next.op_mode;
    end
    if (pulse_load) begin
      pulse_mode <= s1_mode;
    end
  end

  rfbc_tick u_tick (
    .clk      (clk),
    .rst      (rst),
    .advance  (tick_accept),
    .buttons  (tick_data),
    .lvl_next (lvl_next)
  );

  rfbc_scale u_scale_red (
    .clk        (clk),
    .level      (lvl_next.red_level),
    .period     (period_load),
    .prod_load  (tick_accept),
    .pulse_load (pulse_load),
    .pulse      (red_pulse)
  );

  rfbc_scale u_scale_green (
    .clk        (clk),
    .level      (lvl_next.green_level),
    .period     (period_load),
    .prod_load  (tick_accept),
    .pulse_load (pulse_load),
    .pulse      (green_pulse)
  );

  rfbc_scale u_scale_blue (
    .clk        (clk),
    .level      (lvl_next.blue_level),
    .period     (period_load),
    .prod_load  (tick_accept),
    .pulse_load (pulse_load),
    .pulse      (blue_pulse)
  );

  assign pulse_data.red_pulse   = red_pulse;
  assign pulse_data.green_pulse = green_pulse;
  assign pulse_data.blue_pulse  = blue_pulse;
  assign pulse_data.mode_now    = pulse_mode;

  // Next mode is one of the manual ones
  assign mode_manual = lvl_next.op_mode != rfbc_pkg::MODE_AUTO;

  // Full pipeline with a stalled result must block new ticks
  `RFBC_ASSERT(a_full_blocks, s1_valid && pulse_valid && pulse_stall |-> tick_stall)
  // A result only appears from a filled product stage
  `RFBC_ASSERT(a_pulse_from_s1, $rose(pulse_valid) |-> $past(s1_valid))
  // Once a manual mode is taken, auto fade never returns
  `RFBC_ASSERT(a_mode_sticky, tick_accept && mode_manual |=> mode_manual)
  // Reset empties both stages
  `RFBC_ASSERT_RST(a_reset_empty, rst |=> !s1_valid && !pulse_valid)

endmodule

>>> sim/tb_rgb_fader_button_controller.sv
// Self-checking testbench for the RGB fader button controller: tick stimulus,
// a tick-by-tick predictor of levels, speed, button counters and mode, and a
// result checker. Depends on rfbc_pkg and the rgb_fader_button_controller RTL.
module tb_rgb_fader_button_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PULSE_DIV   = 1000;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          SEG_TICKS   = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              tick_valid = 1'b0;
  logic              tick_stall;
  rfbc_pkg::tick_t   tick_data = '0;
  logic              pulse_valid;
  logic              pulse_stall = 1'b0;
  rfbc_pkg::pulse_t  pulse_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data = '0;

  // Side-band for directed rows whose result is typed in by hand
  logic              tick_typed = 1'b0;
  rfbc_pkg::pulse_t  tick_want = '0;

  int                idle_pct = 18;
  int                stall_pct = 18;
  int                ticks_sent = 0;
  int                pulses_seen = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  rfbc_pkg::pulse_t  pending_pulses[$];

  // Predictor state
  int unsigned       red_lv, grn_lv, blu_lv;
  int unsigned       fade_rate, inc_hold, dec_hold, press_count;
  logic [2:0]        colour_phase;
  rfbc_pkg::mode_t   cur_mode;
  logic [15:0]       pwm_period;

  rgb_fader_button_controller dut (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick_data   (tick_data),
    .pulse_valid (pulse_valid),
    .pulse_stall (pulse_stall),
    .pulse_data  (pulse_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_fader();
    red_lv       = rfbc_pkg::RED_RESET;
    grn_lv       = rfbc_pkg::GREEN_RESET;
    blu_lv       = rfbc_pkg::BLUE_RESET;
    colour_phase = rfbc_pkg::PHASE_RG;
    fade_rate    = rfbc_pkg::SPEED_MIN;
    cur_mode     = rfbc_pkg::MODE_AUTO;
    inc_hold     = 0;
    dec_hold     = 0;
    press_count  = 0;
    pwm_period   = rfbc_pkg::PERIOD_RESET;
  endfunction

  function automatic int unsigned nudge_level(int unsigned lv, bit up);
    if (up) return (lv < rfbc_pkg::LEVEL_MAX) ? lv + 1 : rfbc_pkg::LEVEL_MAX;
    return (lv > rfbc_pkg::LEVEL_MIN) ? lv - 1 : rfbc_pkg::LEVEL_MIN;
  endfunction

  // Step the colour that the manual mode owns
  function automatic void nudge_manual(bit up);
    case (cur_mode)
      rfbc_pkg::MODE_RED:   red_lv = nudge_level(red_lv, up);
      rfbc_pkg::MODE_GREEN: grn_lv = nudge_level(grn_lv, up);
      rfbc_pkg::MODE_BLUE:  blu_lv = nudge_level(blu_lv, up);
      default: ;
    endcase
  endfunction

  // Move rate/10 from the falling colour to the rising one, then clamp
  function automatic void fade_colours();
    int unsigned st, r, g, b;
    st = fade_rate / 10;
    r = red_lv;
    g = grn_lv;
    b = blu_lv;
    if (colour_phase[0]) begin
      r -= st;
      g += st;
    end else if (colour_phase[1]) begin
      g -= st;
      b += st;
    end else if (colour_phase[2]) begin
      b -= st;
      r += st;
    end
    if (r < rfbc_pkg::LEVEL_MIN) r = rfbc_pkg::LEVEL_MIN;
    if (g < rfbc_pkg::LEVEL_MIN) g = rfbc_pkg::LEVEL_MIN;
    if (b < rfbc_pkg::LEVEL_MIN) b = rfbc_pkg::LEVEL_MIN;
    if (r > rfbc_pkg::LEVEL_MAX) begin
      r = rfbc_pkg::LEVEL_MAX;
      colour_phase = (colour_phase & ~rfbc_pkg::PHASE_BR) | rfbc_pkg::PHASE_RG;
    end
    if (g > rfbc_pkg::LEVEL_MAX) begin
      g = rfbc_pkg::LEVEL_MAX;
      colour_phase = (colour_phase & ~rfbc_pkg::PHASE_RG) | rfbc_pkg::PHASE_GB;
    end
    if (b > rfbc_pkg::LEVEL_MAX) begin
      b = rfbc_pkg::LEVEL_MAX;
      colour_phase = (colour_phase & ~rfbc_pkg::PHASE_GB) | rfbc_pkg::PHASE_BR;
    end
    red_lv = r;
    grn_lv = g;
    blu_lv = b;
  endfunction

  function automatic logic [rfbc_pkg::PULSE_W-1:0] scale_level(int unsigned lv);
    int unsigned prod;
    prod = lv * pwm_period;
    return rfbc_pkg::PULSE_W'(prod / PULSE_DIV);
  endfunction

  // One update tick: fade, increment button, decrement button, then scale
  function automatic rfbc_pkg::pulse_t fader_tick(logic inc, logic dec);
    rfbc_pkg::pulse_t res;
    if (cur_mode == rfbc_pkg::MODE_AUTO) fade_colours();

    if (inc) begin
      if (cur_mode == rfbc_pkg::MODE_AUTO && fade_rate < rfbc_pkg::SPEED_MAX) fade_rate++;
      if (inc_hold < rfbc_pkg::HOLD_SAT) inc_hold++;
      if (inc_hold <= 2 || inc_hold > rfbc_pkg::REPEAT_AFTER) nudge_manual(1'b1);
    end else begin
      if (press_count == rfbc_pkg::PRESS_ONE && inc_hold > rfbc_pkg::HOLD_SHORT)
        cur_mode = rfbc_pkg::MODE_RED;
      press_count = 0;
      inc_hold    = 0;
      dec_hold    = 0;
    end

    if (dec) begin
      if (cur_mode == rfbc_pkg::MODE_AUTO && fade_rate > rfbc_pkg::SPEED_MIN) fade_rate--;
      if (dec_hold < rfbc_pkg::HOLD_SAT) dec_hold++;
      if (dec_hold > rfbc_pkg::HOLD_SHORT) cur_mode = rfbc_pkg::MODE_BLUE;
      nudge_manual(1'b0);
    end else begin
      if (dec_hold > 0 && dec_hold <= rfbc_pkg::HOLD_SHORT &&
          press_count < rfbc_pkg::PRESS_SAT) press_count++;
      dec_hold = 0;
      if (press_count == rfbc_pkg::PRESS_TWO) cur_mode = rfbc_pkg::MODE_GREEN;
    end

    res.red_pulse   = scale_level(red_lv);
    res.green_pulse = scale_level(grn_lv);
    res.blue_pulse  = scale_level(blu_lv);
    res.mode_now    = cur_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer, then predict each tick transfer
  always @(posedge clk) begin
    rfbc_pkg::pulse_t want;
    if (!rst && pulse_valid && !pulse_stall) begin
      pulses_seen <= pulses_seen + 1;
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, pulse_data);
        mismatch_count++;
      end else begin
        want = pending_pulses.pop_front();
        check_field("red_pulse", want.red_pulse, pulse_data.red_pulse);
        check_field("green_pulse", want.green_pulse, pulse_data.green_pulse);
        check_field("blue_pulse", want.blue_pulse, pulse_data.blue_pulse);
        check_field("mode_now", want.mode_now, pulse_data.mode_now);
      end
    end
    if (!rst && tick_valid && !tick_stall) begin
      want = fader_tick(tick_data.inc_button, tick_data.dec_button);
      pending_pulses.push_back(tick_typed ? tick_want : want);
    end
  end

  // Random receiver stall
  always @(posedge clk) begin
    pulse_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rgb_fader_button_controller");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one tick, with a random gap before it, and hold until transferred
  task automatic send_tick(logic inc, logic dec, logic typed, rfbc_pkg::pulse_t want);
    while ($urandom_range(99) < idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data  <= '{inc_button: inc, dec_button: dec};
    tick_typed <= typed;
    tick_want  <= want;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(logic inc, logic dec, int n);
    for (int k = 0; k < n; k++) send_tick(inc, dec, 1'b0, '0);
  endtask

  // Drain every result, let the pipeline settle, then write the period
  task automatic write_period(logic [15:0] value);
    tick_valid <= 1'b0;
    while (pulses_seen != ticks_sent) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    pwm_period = value;
  endtask

  // Auto-mode sequences; each starts with a release so no press is counted
  task automatic fade_seq();
    int pick;
    pick = $urandom_range(99);
    send_run(1'b0, 1'b0, 1);
    if (pick < 35) begin
      send_run(1'b1, 1'b0, $urandom_range(1, 120));
    end else if (pick < 60) begin
      send_run(1'b0, 1'b1, $urandom_range(1, 60));
    end else if (pick < 85) begin
      send_run(1'b0, 1'b0, $urandom_range(1, 60));
    end else begin
      // brief overlap of both buttons, too short to pick a mode
      send_run(1'b1, 1'b1, $urandom_range(1, 3));
      send_run(1'b1, 1'b0, $urandom_range(0, 2));
    end
    send_run(1'b0, 1'b0, 1);
  endtask

  // Manual-mode sequences: mode picks, level adjustment and noise
  task automatic manual_seq(int kind);
    case (kind)
      0: begin
        // one short press under a long increment hold: red
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, $urandom_range(1, 4));
        send_run(1'b1, 1'b1, $urandom_range(1, 5));
        send_run(1'b1, 1'b0, $urandom_range(21, 30));
        send_run(1'b0, 1'b0, 1);
      end
      1: begin
        // two short presses under an increment hold: green
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, $urandom_range(1, 4));
        send_run(1'b1, 1'b1, $urandom_range(1, 20));
        send_run(1'b1, 1'b0, $urandom_range(1, 4));
        send_run(1'b1, 1'b1, $urandom_range(1, 20));
        send_run(1'b1, 1'b0, 1);
        send_run(1'b0, 1'b0, 1);
      end
      2: begin
        // long decrement hold under an increment hold: blue
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, $urandom_range(0, 3));
        send_run(1'b1, 1'b1, $urandom_range(21, 35));
        send_run(1'b0, 1'b0, 1);
      end
      3: begin
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, $urandom_range(1, 45));
        send_run(1'b0, 1'b0, 1);
      end
      4: begin
        send_run(1'b0, 1'b0, 1);
        send_run(1'b0, 1'b1, $urandom_range(1, 40));
        send_run(1'b0, 1'b0, 1);
      end
      default: begin
        int n;
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      end
    endcase
  endtask

  task automatic pick_manual_seq();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12)      manual_seq(0);
    else if (pick < 24) manual_seq(1);
    else if (pick < 36) manual_seq(2);
    else if (pick < 61) manual_seq(3);
    else if (pick < 86) manual_seq(4);
    else                manual_seq(5);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: reset values, zero and full period, button combinations
  // ---------------------------------------------------------------------------
  typedef struct {
    bit               wr_period;
    logic [15:0]      period_val;
    logic             inc;
    logic             dec;
    int               reps;
    bit               typed;
    rfbc_pkg::pulse_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 12;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, 16'd0,     1'b0, 1'b0, 1, 1'b1,
      '{15'd2885,  15'd113, 15'd113, rfbc_pkg::MODE_AUTO}},
    '{1'b1, 16'd0,     1'b0, 1'b0, 1, 1'b1,
      '{15'd0,     15'd0,   15'd0,   rfbc_pkg::MODE_AUTO}},
    '{1'b1, 16'hFFFF,  1'b0, 1'b0, 1, 1'b1,
      '{15'd16645, 15'd655, 15'd655, rfbc_pkg::MODE_AUTO}},
    '{1'b1, 16'd11362, 1'b1, 1'b0, 1, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b1, 1, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 1, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b1, 2, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 1, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b0, 3, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b1, 1, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b0, 1, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 1, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] fade_periods [4];
    logic [15:0] manual_periods [5];
    int          seg_start;

    reset_fader();
    fade_periods   = '{16'($urandom), 16'hFFFF, 16'd1000, 16'($urandom)};
    manual_periods = '{16'($urandom), 16'd0, 16'hFFFF, 16'($urandom),
                       rfbc_pkg::PERIOD_RESET};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_period) write_period(dir_tab[i].period_val);
      for (int k = 0; k < dir_tab[i].reps; k++)
        send_tick(dir_tab[i].inc, dir_tab[i].dec, dir_tab[i].typed, dir_tab[i].want);
    end

    // Auto fade segments; the third runs without gaps or stalls
    for (int s = 0; s < 4; s++) begin
      write_period(fade_periods[s]);
      idle_pct  = (s == 2) ? 0 : 18;
      stall_pct = idle_pct;
      seg_start = ticks_sent;
      while (ticks_sent - seg_start < SEG_TICKS) fade_seq();
    end

    // Manual segments, the first opened by a mode pick; the fourth runs without gaps
    for (int s = 0; s < 5; s++) begin
      write_period(manual_periods[s]);
      idle_pct  = (s == 3) ? 0 : 18;
      stall_pct = idle_pct;
      seg_start = ticks_sent;
      if (s == 0) manual_seq($urandom_range(0, 2));
      while (ticks_sent - seg_start < SEG_TICKS) pick_manual_seq();
    end

    // Drain and report
    tick_valid <= 1'b0;
    while (pulses_seen != ticks_sent) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_pulses.size() != 0) begin
      $display("%0t: results missing, expected %0d more, got none",
               $time, pending_pulses.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS rgb_fader_button_controller");
    end else begin
      $display("FAIL rgb_fader_button_controller");
    end
    $finish;
  end

endmodule
